/* rtl/dpe_pkg.sv */
// ----------------------------------------------------------------------------
// Data-processing execute package
// Widths, opcode and shift type codes, and the barrel shifter result bundle.
// ----------------------------------------------------------------------------
package dpe_pkg;

  localparam int WORD_W    = 32;
  localparam int REG_IDX_W = 4;

  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'ha,
    OP_ORR = 4'hc,
    OP_MOV = 4'hd
  } alu_op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_type_t;

  typedef struct packed {
    logic [WORD_W-1:0] operand;
    logic              carry;
    logic              ok;
  } shift_res_t;

endpackage

/* rtl/dpe_in_if.sv */
// ----------------------------------------------------------------------------
// Execute input channel
// Carries one instruction word with its register operands and current carry.
// ----------------------------------------------------------------------------
interface dpe_in_if import dpe_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instruction;
  logic [WORD_W-1:0] rn_value;
  logic [WORD_W-1:0] rm_value;
  logic              carry_in;

  modport source (
    output valid, instruction, rn_value, rm_value, carry_in,
    input  ready
  );

  modport sink (
    input  valid, instruction, rn_value, rm_value, carry_in,
    output ready
  );

endinterface

/* rtl/dpe_out_if.sv */
// ----------------------------------------------------------------------------
// Execute result channel
// Carries the ALU result, destination, write enable and condition flags.
// ----------------------------------------------------------------------------
interface dpe_out_if import dpe_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [WORD_W-1:0]    result;
  logic [REG_IDX_W-1:0] dest_reg;
  logic                 write_back;
  logic                 set_flags;
  logic                 flag_n;
  logic                 flag_z;
  logic                 flag_c;
  logic                 supported;

  modport source (
    output valid, result, dest_reg, write_back, set_flags,
           flag_n, flag_z, flag_c, supported,
    input  ready
  );

  modport sink (
    input  valid, result, dest_reg, write_back, set_flags,
           flag_n, flag_z, flag_c, supported,
    output ready
  );

endinterface

/* rtl/dpe_shifter.sv */
// ----------------------------------------------------------------------------
// Operand 2 barrel shifter
// Builds the second operand from a rotated immediate or a constant shift of
// Rm, together with the shifter carry.
// ----------------------------------------------------------------------------
module dpe_shifter import dpe_pkg::*; (
  input  logic [WORD_W-1:0] instruction,
  input  logic [WORD_W-1:0] rm_value,
  input  logic              carry_in,
  output shift_res_t        shift_res
);

  logic [4:0]          rot_amt;
  logic [4:0]          sh_amt;
  shift_type_t         sh_type;
  logic [2*WORD_W-1:0] imm_dbl;
  logic [2*WORD_W-1:0] rm_dbl;
  logic [WORD_W-1:0]   imm_rot;
  logic [WORD_W-1:0]   rm_rot;
  logic [WORD_W:0]     lsl_ext;
  logic [WORD_W:0]     lsr_ext;
  logic [WORD_W:0]     asr_ext;
  logic                sign;

  assign rot_amt = {instruction[11:8], 1'b0};
  assign sh_amt  = instruction[11:7];
  assign sh_type = shift_type_t'(instruction[6:5]);
  assign sign    = rm_value[WORD_W-1];

  assign imm_dbl = {{(WORD_W-8){1'b0}}, instruction[7:0],
                    {(WORD_W-8){1'b0}}, instruction[7:0]} >> rot_amt;
  assign imm_rot = imm_dbl[WORD_W-1:0];
  assign rm_dbl  = {rm_value, rm_value} >> sh_amt;
  assign rm_rot  = rm_dbl[WORD_W-1:0];
  assign lsl_ext = {1'b0, rm_value} << sh_amt;
  assign lsr_ext = {rm_value, 1'b0} >> sh_amt;
  assign asr_ext = $signed({rm_value, 1'b0}) >>> sh_amt;

  always_comb begin
    shift_res.operand = imm_rot;
    shift_res.carry   = carry_in;
    shift_res.ok      = 1'b1;
    if (instruction[25]) begin
      shift_res.operand = imm_rot;
      shift_res.carry   = (rot_amt == 5'd0) ? carry_in : imm_rot[WORD_W-1];
    end else if (instruction[4]) begin
      shift_res.ok = 1'b0;
    end else begin
      unique case (sh_type)
        SH_LSL: begin
          if (sh_amt == 5'd0) begin
            shift_res.operand = rm_value;
            shift_res.carry   = carry_in;
          end else begin
            shift_res.operand = lsl_ext[WORD_W-1:0];
            shift_res.carry   = lsl_ext[WORD_W];
          end
        end
        SH_LSR: begin
          if (sh_amt == 5'd0) begin
            shift_res.operand = '0;
            shift_res.carry   = sign;
          end else begin
            shift_res.operand = lsr_ext[WORD_W:1];
            shift_res.carry   = lsr_ext[0];
          end
        end
        SH_ASR: begin
          if (sh_amt == 5'd0) begin
            shift_res.operand = {WORD_W{sign}};
            shift_res.carry   = sign;
          end else begin
            shift_res.operand = asr_ext[WORD_W:1];
            shift_res.carry   = asr_ext[0];
          end
        end
        SH_ROR: begin
          if (sh_amt == 5'd0) begin
            shift_res.operand = {carry_in, rm_value[WORD_W-1:1]};
            shift_res.carry   = rm_value[0];
          end else begin
            shift_res.operand = rm_rot;
            shift_res.carry   = rm_rot[WORD_W-1];
          end
        end
        default: begin
          shift_res.ok = 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/data_processing_execute_top.sv */
// ----------------------------------------------------------------------------
// Data-processing execute stage
// Barrel shifter and ALU for one data-processing instruction per word.
// ----------------------------------------------------------------------------
// The block takes one instruction word per clock while in_ch.ready is high and
// returns one result word for each, in order: the word is captured in an input
// register, the operand 2 shifter and the 32-bit adder or logic unit work on
// it in the next cycle, and the result register presents it. Both registers
// hold back under a stalled result channel, so a word can still be
// accepted while a finished result waits to be taken. Unhandled opcodes and
// register-specified shifts come back with supported low, every other result
// field zero except the destination index.
module data_processing_execute_top import dpe_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  dpe_in_if.sink        in_ch,
  dpe_out_if.source     out_ch
);

  logic                 s1_valid_r;
  logic [WORD_W-1:0]    s1_insn_r;
  logic [WORD_W-1:0]    s1_rn_r;
  logic [WORD_W-1:0]    s1_rm_r;
  logic                 s1_cin_r;
  logic                 s1_ready;
  logic                 s2_ready;

  logic                 out_valid_r;
  logic [WORD_W-1:0]    result_r;
  logic [REG_IDX_W-1:0] dest_reg_r;
  logic                 write_back_r;
  logic                 set_flags_r;
  logic                 flag_n_r;
  logic                 flag_z_r;
  logic                 flag_c_r;
  logic                 supported_r;

  shift_res_t           sh;
  alu_op_t              opcode;
  logic [WORD_W-1:0]    add_a;
  logic [WORD_W-1:0]    add_b;
  logic                 add_ci;
  logic [WORD_W:0]      add_sum;
  logic [WORD_W-1:0]    alu_res;
  logic                 alu_c;
  logic                 op_ok;
  logic                 op_wb;
  logic                 item_ok;
  logic [WORD_W-1:0]    result_nxt;

  assign s2_ready    = !out_valid_r || out_ch.ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (s1_ready && in_ch.valid) begin
      s1_insn_r <= in_ch.instruction;
      s1_rn_r   <= in_ch.rn_value;
      s1_rm_r   <= in_ch.rm_value;
      s1_cin_r  <= in_ch.carry_in;
    end
  end

  dpe_shifter u_shifter (
    .instruction (s1_insn_r),
    .rm_value    (s1_rm_r),
    .carry_in    (s1_cin_r),
    .shift_res   (sh)
  );

  assign opcode  = alu_op_t'(s1_insn_r[24:21]);
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_ci};

  always_comb begin
    add_a  = s1_rn_r;
    add_b  = ~sh.operand;
    add_ci = 1'b1;
    unique case (opcode)
      OP_RSB: begin
        add_a = sh.operand;
        add_b = ~s1_rn_r;
      end
      OP_ADD: begin
        add_b  = sh.operand;
        add_ci = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    alu_res = add_sum[WORD_W-1:0];
    alu_c   = sh.carry;
    op_ok   = 1'b1;
    op_wb   = 1'b1;
    unique case (opcode)
      OP_AND: alu_res = s1_rn_r & sh.operand;
      OP_EOR: alu_res = s1_rn_r ^ sh.operand;
      OP_ORR: alu_res = s1_rn_r | sh.operand;
      OP_MOV: alu_res = sh.operand;
      OP_TST: begin
        alu_res = s1_rn_r & sh.operand;
        op_wb   = 1'b0;
      end
      OP_TEQ: begin
        alu_res = s1_rn_r ^ sh.operand;
        op_wb   = 1'b0;
      end
      OP_SUB, OP_RSB, OP_ADD: begin
        alu_res = add_sum[WORD_W-1:0];
        alu_c   = add_sum[WORD_W];
      end
      OP_CMP: begin
        alu_res = add_sum[WORD_W-1:0];
        alu_c   = add_sum[WORD_W];
        op_wb   = 1'b0;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  assign item_ok    = op_ok && sh.ok;
  assign result_nxt = item_ok ? alu_res : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
    if (s2_ready && s1_valid_r) begin
      result_r     <= result_nxt;
      dest_reg_r   <= s1_insn_r[15:12];
      write_back_r <= item_ok && op_wb;
      set_flags_r  <= item_ok && s1_insn_r[20];
      flag_n_r     <= result_nxt[WORD_W-1];
      flag_z_r     <= item_ok && (alu_res == '0);
      flag_c_r     <= item_ok && alu_c;
      supported_r  <= item_ok;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.result     = result_r;
  assign out_ch.dest_reg   = dest_reg_r;
  assign out_ch.write_back = write_back_r;
  assign out_ch.set_flags  = set_flags_r;
  assign out_ch.flag_n     = flag_n_r;
  assign out_ch.flag_z     = flag_z_r;
  assign out_ch.flag_c     = flag_c_r;
  assign out_ch.supported  = supported_r;

`ifndef ASSERT_OFF
  a_out_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result word appeared without an instruction in stage 1");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_insn_r)))
    else $error("stage 1 word lost while the result register was stalled");

  a_unsupported_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !supported_r) |-> (result_r == '0 && !write_back_r &&
      !set_flags_r && !flag_n_r && !flag_z_r && !flag_c_r))
    else $error("unsupported instruction produced nonzero result fields");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && supported_r) |-> (flag_z_r == (result_r == '0)))
    else $error("zero flag disagrees with the result");
`endif

endmodule

/* tb/data_processing_execute_top_tb.sv */
// ----------------------------------------------------------------------------
// Data-processing execute stage testbench
// Drives instruction words with register operands through the execute stage
// and checks every result word against an in-bench model of the barrel shifter
// and ALU. A directed set covers each opcode and shifter corner, then random
// words run under several flow-control patterns on both channels.
// ----------------------------------------------------------------------------
module data_processing_execute_top_tb;

  import dpe_pkg::*;

  localparam logic [3:0] COND_AL     = 4'he;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_WAIT  = 6;

  typedef struct packed {
    logic [WORD_W-1:0]    result;
    logic [REG_IDX_W-1:0] dest_reg;
    logic                 write_back;
    logic                 set_flags;
    logic                 flag_n;
    logic                 flag_z;
    logic                 flag_c;
    logic                 supported;
  } exec_result_t;

  logic clk;
  logic rst_n;

  dpe_in_if  in_ch ();
  dpe_out_if out_ch ();

  data_processing_execute_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  exec_result_t expected_results[$];
  int           idle_pct;
  int           stall_pct;
  int           failures;
  int           words_sent;
  int           unhandled_sent;
  int           results_checked;
  int           cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_handled(input logic [3:0] opc);
    case (opc)
      OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
      OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic exec_result_t predict_execute(input logic [31:0] insn,
                                                   input logic [31:0] rn,
                                                   input logic [31:0] rm,
                                                   input logic        cin);
    exec_result_t        r;
    logic [31:0]         op2;
    logic [31:0]         res;
    logic                sh_c;
    logic                c;
    logic                wb;
    logic                form_ok;
    logic [4:0]          amt;
    logic [4:0]          rot;
    logic [63:0]         wide;
    logic [32:0]         ext;
    logic signed [32:0]  sext;
    logic [3:0]          opc;

    opc     = insn[24:21];
    amt     = insn[11:7];
    rot     = {insn[11:8], 1'b0};
    form_ok = 1'b1;
    op2     = '0;
    sh_c    = cin;
    if (insn[25]) begin
      wide = {24'b0, insn[7:0], 24'b0, insn[7:0]} >> rot;
      op2  = wide[31:0];
      sh_c = (rot == 5'd0) ? cin : op2[31];
    end else if (insn[4]) begin
      form_ok = 1'b0;
    end else begin
      case (shift_type_t'(insn[6:5]))
        SH_LSL: begin
          if (amt == 5'd0) begin
            op2  = rm;
            sh_c = cin;
          end else begin
            ext  = {1'b0, rm} << amt;
            op2  = ext[31:0];
            sh_c = ext[32];
          end
        end
        SH_LSR: begin
          if (amt == 5'd0) begin
            op2  = '0;
            sh_c = rm[31];
          end else begin
            ext  = {rm, 1'b0} >> amt;
            op2  = ext[32:1];
            sh_c = ext[0];
          end
        end
        SH_ASR: begin
          if (amt == 5'd0) begin
            op2  = {32{rm[31]}};
            sh_c = rm[31];
          end else begin
            sext = {rm, 1'b0};
            sext = sext >>> amt;
            op2  = sext[32:1];
            sh_c = sext[0];
          end
        end
        default: begin
          if (amt == 5'd0) begin
            op2  = {cin, rm[31:1]};
            sh_c = rm[0];
          end else begin
            wide = {rm, rm} >> amt;
            op2  = wide[31:0];
            sh_c = op2[31];
          end
        end
      endcase
    end

    wb  = 1'b1;
    res = '0;
    c   = 1'b0;
    case (opc)
      OP_AND: begin res = rn & op2; c = sh_c; end
      OP_EOR: begin res = rn ^ op2; c = sh_c; end
      OP_SUB: begin res = rn - op2; c = (rn >= op2); end
      OP_RSB: begin res = op2 - rn; c = (op2 >= rn); end
      OP_ADD: begin
        ext = {1'b0, rn} + {1'b0, op2};
        res = ext[31:0];
        c   = ext[32];
      end
      OP_TST: begin res = rn & op2; c = sh_c; wb = 1'b0; end
      OP_TEQ: begin res = rn ^ op2; c = sh_c; wb = 1'b0; end
      OP_CMP: begin res = rn - op2; c = (rn >= op2); wb = 1'b0; end
      OP_ORR: begin res = rn | op2; c = sh_c; end
      OP_MOV: begin res = op2; c = sh_c; end
      default: form_ok = 1'b0;
    endcase

    r          = '0;
    r.dest_reg = insn[15:12];
    if (form_ok) begin
      r.result     = res;
      r.write_back = wb;
      r.set_flags  = insn[20];
      r.flag_n     = res[31];
      r.flag_z     = (res == 32'd0);
      r.flag_c     = c;
      r.supported  = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] dp_word(input logic        imm,
                                          input logic [3:0]  opc,
                                          input logic        s,
                                          input logic [3:0]  rn_idx,
                                          input logic [3:0]  rd,
                                          input logic [11:0] op2);
    return {COND_AL, 2'b00, imm, opc, s, rn_idx, rd, op2};
  endfunction

  function automatic logic [11:0] shift_op2(input logic [4:0]  amt,
                                            input shift_type_t typ,
                                            input logic [3:0]  rm_idx);
    return {amt, typ, 1'b0, rm_idx};
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [31:0] insn;
    logic [3:0]  opc;
    bit          want_handled;

    insn         = $urandom;
    want_handled = ($urandom_range(0, 9) != 0);
    opc          = 4'($urandom_range(0, 15));
    while (is_handled(opc) != want_handled) opc = 4'($urandom_range(0, 15));
    insn[24:21] = opc;
    if (insn[25]) begin
      if ($urandom_range(0, 3) == 0) insn[11:8] = 4'd0;
    end else begin
      insn[4] = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 5))
        0: insn[11:7] = 5'd0;
        1: insn[11:7] = 5'd31;
        2: insn[11:7] = 5'd1;
        default: ;
      endcase
    end
    return insn;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  task automatic send_word(input logic [31:0] insn, input logic [31:0] rn,
                           input logic [31:0] rm, input logic cin);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.instruction <= insn;
    in_ch.rn_value    <= rn;
    in_ch.rm_value    <= rm;
    in_ch.carry_in    <= cin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(predict_execute(insn, rn, rm, cin));
    words_sent++;
    if (!is_handled(insn[24:21]) || (!insn[25] && insn[4])) unhandled_sent++;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(random_instruction(), random_operand(), random_operand(),
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_until_empty();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_every_opcode();
    idle_pct  = 0;
    stall_pct = 0;
    for (int k = 0; k < 16; k++) begin
      send_word(dp_word(1'b1, k[3:0], 1'b1, 4'd1, k[3:0], {4'd4, 8'ha5}),
                32'h1234_5678, $urandom, k[0]);
    end
  endtask

  task automatic test_shifter_corners();
    // An immediate with no rotation passes the incoming carry through.
    send_word(dp_word(1'b1, OP_AND, 1'b1, 4'd2, 4'd3, {4'd0, 8'hff}),
              32'hffff_ffff, 32'h0, 1'b1);
    send_word(dp_word(1'b0, OP_MOV, 1'b1, 4'd0, 4'd4, shift_op2(5'd0, SH_LSL, 4'd5)),
              32'h0, 32'h8000_0000, 1'b1);
    send_word(dp_word(1'b0, OP_EOR, 1'b1, 4'd1, 4'd5, shift_op2(5'd31, SH_LSL, 4'd6)),
              32'h0, 32'h0000_0001, 1'b0);
    // A zero amount on the right shifts and rotate means 32 or the extended rotate.
    send_word(dp_word(1'b0, OP_ADD, 1'b1, 4'd1, 4'd6, shift_op2(5'd0, SH_LSR, 4'd7)),
              32'hffff_ffff, 32'h8000_0000, 1'b0);
    send_word(dp_word(1'b0, OP_CMP, 1'b1, 4'd1, 4'd7, shift_op2(5'd0, SH_ASR, 4'd8)),
              32'h0, 32'h8000_0000, 1'b0);
    send_word(dp_word(1'b0, OP_TST, 1'b1, 4'd1, 4'd8, shift_op2(5'd0, SH_ROR, 4'd9)),
              32'hffff_ffff, 32'h0000_0001, 1'b1);
    send_word(dp_word(1'b0, OP_ORR, 1'b0, 4'd1, 4'd9, shift_op2(5'd7, SH_ROR, 4'd2)),
              32'h0, 32'h0000_00c0, 1'b0);
    send_word(dp_word(1'b0, OP_SUB, 1'b0, 4'd1, 4'd10, shift_op2(5'd0, SH_LSL, 4'd1)),
              32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_word(dp_word(1'b1, OP_ADD, 1'b1, 4'd1, 4'd11, {4'd0, 8'h01}),
              32'hffff_ffff, 32'h0, 1'b0);
    // A register-specified shift is reported as unsupported.
    send_word(dp_word(1'b0, OP_ORR, 1'b1, 4'd1, 4'd12, {4'd3, 1'b0, SH_LSL, 1'b1, 4'd2}),
              32'h5555_5555, 32'haaaa_aaaa, 1'b1);
    send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
  endtask

  task automatic test_back_to_back();
    idle_pct  = 0;
    stall_pct = 0;
    run_random(130);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 52;
    stall_pct = 0;
    run_random(120);
  endtask

  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 52;
    run_random(120);
  endtask

  task automatic test_both_sides_idle();
    idle_pct  = 19;
    stall_pct = 19;
    run_random(100);
  endtask

  task automatic test_pause_until_empty();
    idle_pct  = 0;
    stall_pct = 19;
    repeat (4) begin
      run_random(10);
      wait_until_empty();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    exec_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word arrived with nothing expected");
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("result", want.result, out_ch.result);
        check_field("dest_reg", 32'(want.dest_reg), 32'(out_ch.dest_reg));
        check_field("write_back", 32'(want.write_back), 32'(out_ch.write_back));
        check_field("set_flags", 32'(want.set_flags), 32'(out_ch.set_flags));
        check_field("flag_n", 32'(want.flag_n), 32'(out_ch.flag_n));
        check_field("flag_z", 32'(want.flag_z), 32'(out_ch.flag_z));
        check_field("flag_c", 32'(want.flag_c), 32'(out_ch.flag_c));
        check_field("supported", 32'(want.supported), 32'(out_ch.supported));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.instruction = '0;
    in_ch.rn_value    = '0;
    in_ch.rm_value    = '0;
    in_ch.carry_in    = 1'b0;
    out_ch.ready      = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    failures          = 0;
    words_sent        = 0;
    unhandled_sent    = 0;
    results_checked   = 0;
    cycle_count       = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_every_opcode();
    test_shifter_corners();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    test_pause_until_empty();

    wait_until_empty();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d words (%0d unhandled or register-shift) and checked %0d results,",
             words_sent, unhandled_sent, results_checked);
    $display("with all opcodes, every shift type and idle and stall on both channels.");
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
